@@ rtl/forward_box_blur_3x3_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the forward box blur unit
// Shared concurrent-check shorthands, clocked on clk and gated by rst_n.
// ----------------------------------------------------------------------------
`ifndef FORWARD_BOX_BLUR_3X3_UNIT_MACROS_SVH
`define FORWARD_BOX_BLUR_3X3_UNIT_MACROS_SVH

// same-cycle implication
`define FBB_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define FBB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/fbb_pkg.sv @@
// ----------------------------------------------------------------------------
// fbb_pkg
// Shared widths, metadata struct and reciprocal table for the box blur.
// ----------------------------------------------------------------------------
package fbb_pkg;

    localparam int CH_W   = 16;
    localparam int PIX_W  = 3 * CH_W;
    localparam int SUM_W  = 20;
    localparam int RCP_W  = 25;
    localparam int RCP_SH = 24;
    localparam int POS_W  = 10;
    localparam int CFG_W  = 11;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             last;
    } fbb_meta_t;

    function automatic logic [RCP_W-1:0] fbb_recip(input logic [3:0] num);
        logic [RCP_W-1:0] m;
        case (num)
            4'd1:    m = 25'd16777216;
            4'd2:    m = 25'd8388608;
            4'd3:    m = 25'd5592406;
            4'd4:    m = 25'd4194304;
            4'd5:    m = 25'd3355444;
            4'd6:    m = 25'd2796203;
            4'd7:    m = 25'd2396746;
            4'd8:    m = 25'd2097152;
            4'd9:    m = 25'd1864136;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

@@ rtl/fbb_px_if.sv @@
// ----------------------------------------------------------------------------
// fbb_px_if
// Source pixel request channel: valid/ready plus RGB payload.
// ----------------------------------------------------------------------------
interface fbb_px_if;
    logic        valid;
    logic        ready;
    logic [15:0] red_in;
    logic [15:0] green_in;
    logic [15:0] blue_in;

    modport source (output valid, red_in, green_in, blue_in, input ready);
    modport sink   (input valid, red_in, green_in, blue_in, output ready);
endinterface

@@ rtl/fbb_res_if.sv @@
// ----------------------------------------------------------------------------
// fbb_res_if
// Result request channel: valid/ready plus position, RGB mean and run end.
// ----------------------------------------------------------------------------
interface fbb_res_if;
    logic        valid;
    logic        ready;
    logic [9:0]  out_row;
    logic [9:0]  out_col;
    logic [15:0] red_out;
    logic [15:0] green_out;
    logic [15:0] blue_out;
    logic        last_of_run;

    modport source (output valid, out_row, out_col, red_out, green_out, blue_out,
                    last_of_run, input ready);
    modport sink   (input valid, out_row, out_col, red_out, green_out, blue_out,
                    last_of_run, output ready);
endinterface

@@ rtl/fbb_line_mem.sv @@
// ----------------------------------------------------------------------------
// fbb_line_mem
// Two line-store banks, one synchronous read port and one write port.
// ----------------------------------------------------------------------------
module fbb_line_mem
    import fbb_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
)
(
    input  logic             clk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    input  logic             wr_en,
    input  logic             wr_bank,
    input  logic [AW-1:0]    wr_addr,
    input  logic [PIX_W-1:0] wr_data,
    output logic [PIX_W-1:0] rd_data_a,
    output logic [PIX_W-1:0] rd_data_b
);

    logic [PIX_W-1:0] bank_a_mem [DEPTH];
    logic [PIX_W-1:0] bank_b_mem [DEPTH];
    logic [PIX_W-1:0] rd_a_reg;
    logic [PIX_W-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_a_reg <= bank_a_mem[rd_addr];
            rd_b_reg <= bank_b_mem[rd_addr];
        end
        if (wr_en && !wr_bank)
        begin
            bank_a_mem[wr_addr] <= wr_data;
        end
        if (wr_en && wr_bank)
        begin
            bank_b_mem[wr_addr] <= wr_data;
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

@@ rtl/fbb_mean.sv @@
// ----------------------------------------------------------------------------
// fbb_mean
// Three-stage mean pipeline: reciprocal lookup, multiply, result register.
// ----------------------------------------------------------------------------
module fbb_mean
    import fbb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [SUM_W-1:0] in_sum_r,
    input  logic [SUM_W-1:0] in_sum_g,
    input  logic [SUM_W-1:0] in_sum_b,
    input  logic [3:0]       in_num,
    input  fbb_meta_t        in_meta,
    fbb_res_if.source        res
);

    localparam int PROD_W = SUM_W + RCP_W;

    logic               en;
    logic               a_v_reg;
    logic [SUM_W-1:0]   a_r_reg, a_g_reg, a_b_reg;
    logic [RCP_W-1:0]   a_m_reg;
    fbb_meta_t          a_meta_reg;
    logic               b_v_reg;
    logic [PROD_W-1:0]  b_r_reg, b_g_reg, b_b_reg;
    fbb_meta_t          b_meta_reg;
    logic               c_v_reg;
    logic [CH_W-1:0]    c_r_reg, c_g_reg, c_b_reg;
    fbb_meta_t          c_meta_reg;

    assign en       = !(c_v_reg && !res.ready);
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
        end
        else if (en)
        begin
            a_v_reg <= in_valid;
            b_v_reg <= a_v_reg;
            c_v_reg <= b_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_r_reg    <= in_sum_r;
            a_g_reg    <= in_sum_g;
            a_b_reg    <= in_sum_b;
            a_m_reg    <= fbb_recip(in_num);
            a_meta_reg <= in_meta;
            b_r_reg    <= PROD_W'(a_r_reg) * PROD_W'(a_m_reg);
            b_g_reg    <= PROD_W'(a_g_reg) * PROD_W'(a_m_reg);
            b_b_reg    <= PROD_W'(a_b_reg) * PROD_W'(a_m_reg);
            b_meta_reg <= a_meta_reg;
            c_r_reg    <= b_r_reg[RCP_SH +: CH_W];
            c_g_reg    <= b_g_reg[RCP_SH +: CH_W];
            c_b_reg    <= b_b_reg[RCP_SH +: CH_W];
            c_meta_reg <= b_meta_reg;
        end
    end

    assign res.valid       = c_v_reg;
    assign res.out_row     = c_meta_reg.row;
    assign res.out_col     = c_meta_reg.col;
    assign res.red_out     = c_r_reg;
    assign res.green_out   = c_g_reg;
    assign res.blue_out    = c_b_reg;
    assign res.last_of_run = c_meta_reg.last;

endmodule

@@ rtl/forward_box_blur_3x3_unit.sv @@
// A pixel is read from the line stores in the cycle after its request; its first
// result passes the read and emit states and the mean pipeline registers to the
// result port. A pixel releases 0 to 9 results, one per cycle while the result
// port is ready; new pixels wait on the single read port and result sequencer.
// Reset: counters, window control, bank select and frame size (1024) clear;
// line-store contents are undefined until written.
// ----------------------------------------------------------------------------
// forward_box_blur_3x3_unit
// Streaming 3x3 clipped box mean over a square RGB frame, two line stores.
// ----------------------------------------------------------------------------
`include "forward_box_blur_3x3_unit_macros.svh"

module forward_box_blur_3x3_unit
    import fbb_pkg::*;
#(
    parameter int MAX_SIZE = 1024
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    fbb_px_if.sink           pix,
    fbb_res_if.source        res
);

    localparam int CW = $clog2(MAX_SIZE);
    localparam int NW = CW + 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CFG_W-1:0] size_reg;
    logic [CW-1:0]    row_cnt_reg, col_cnt_reg;
    logic             bank_reg;
    logic [CW-1:0]    r_reg, c_reg;
    logic [PIX_W-1:0] cur_reg;
    logic [1:0]       dy_reg, dx_reg, dxhi_reg;
    logic             lr_reg, lc_reg;
    logic [PIX_W-1:0] win_reg [3][3];

    logic [NW-1:0]    n_eff;
    logic [CW-1:0]    row_clip, col_clip;
    logic [PIX_W-1:0] rd_a, rd_b, newer_pix, older_pix;
    logic             last_r, last_c, have_y, have_x;
    logic [1:0]       dyhi, dxhi;
    logic             done_y, done_x;
    logic             mem_wr;
    logic             mean_valid, mean_ready;
    logic [SUM_W-1:0] sum_r, sum_g, sum_b;
    logic [3:0]       num;
    fbb_meta_t        meta;
    logic [31:0]      out_r32, out_c32;

    always_comb
    begin
        if (size_reg == '0)
            n_eff = NW'(1);
        else if (32'(size_reg) > MAX_SIZE)
            n_eff = NW'(MAX_SIZE);
        else
            n_eff = NW'(size_reg);
    end

    assign row_clip = (NW'(row_cnt_reg) >= n_eff) ? '0 : row_cnt_reg;
    assign col_clip = (NW'(col_cnt_reg) >= n_eff) ? '0 : col_cnt_reg;

    assign pix.ready = (state_reg == ST_IDLE);

    assign mem_wr = (state_reg == ST_RD);

    fbb_line_mem #(
        .DEPTH (MAX_SIZE),
        .AW    (CW)
    ) u_line_mem (
        .clk       (clk),
        .rd_en     (pix.valid && pix.ready),
        .rd_addr   (col_clip),
        .wr_en     (mem_wr),
        .wr_bank   (!bank_reg),
        .wr_addr   (c_reg),
        .wr_data   (cur_reg),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b)
    );

    assign newer_pix = bank_reg ? rd_b : rd_a;
    assign older_pix = bank_reg ? rd_a : rd_b;

    assign last_r = (NW'(r_reg) == n_eff - NW'(1));
    assign last_c = (NW'(c_reg) == n_eff - NW'(1));
    assign have_y = last_r || (r_reg >= CW'(2));
    assign have_x = last_c || (c_reg >= CW'(2));
    assign dyhi   = (r_reg >= CW'(2)) ? 2'd2 : r_reg[1:0];
    assign dxhi   = (c_reg >= CW'(2)) ? 2'd2 : c_reg[1:0];
    assign done_y = !lr_reg || (dy_reg == 2'd0);
    assign done_x = !lc_reg || (dx_reg == 2'd0);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pix.valid)
                    state_next = ST_RD;
            end
            ST_RD:
            begin
                state_next = (have_y && have_x) ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (mean_ready && done_y && done_x)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            size_reg    <= CFG_W'(1024);
            row_cnt_reg <= '0;
            col_cnt_reg <= '0;
            bank_reg    <= 1'b0;
            dy_reg      <= '0;
            dx_reg      <= '0;
            dxhi_reg    <= '0;
            lr_reg      <= 1'b0;
            lc_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                size_reg    <= cfg_wdata;
                row_cnt_reg <= '0;
                col_cnt_reg <= '0;
            end
            else if (state_reg == ST_RD)
            begin
                if (last_c)
                begin
                    col_cnt_reg <= '0;
                    row_cnt_reg <= last_r ? '0 : r_reg + CW'(1);
                    bank_reg    <= !bank_reg;
                end
                else
                begin
                    col_cnt_reg <= c_reg + CW'(1);
                    row_cnt_reg <= r_reg;
                end
            end
            if (state_reg == ST_RD)
            begin
                dy_reg   <= dyhi;
                dx_reg   <= dxhi;
                dxhi_reg <= dxhi;
                lr_reg   <= last_r;
                lc_reg   <= last_c;
            end
            else if (state_reg == ST_EMIT && mean_ready)
            begin
                if (done_x)
                begin
                    dx_reg <= dxhi_reg;
                    dy_reg <= dy_reg - 2'd1;
                end
                else
                begin
                    dx_reg <= dx_reg - 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix.valid && pix.ready)
        begin
            cur_reg <= {pix.blue_in, pix.green_in, pix.red_in};
            r_reg   <= row_clip;
            c_reg   <= col_clip;
        end
        if (state_reg == ST_RD)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i][2] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][0];
            end
            win_reg[0][0] <= cur_reg;
            win_reg[1][0] <= newer_pix;
            win_reg[2][0] <= older_pix;
        end
    end

    always_comb
    begin
        sum_r = '0;
        sum_g = '0;
        sum_b = '0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (i <= int'(dy_reg) && j <= int'(dx_reg))
                begin
                    sum_r = sum_r + SUM_W'(win_reg[i][j][CH_W-1:0]);
                    sum_g = sum_g + SUM_W'(win_reg[i][j][2*CH_W-1:CH_W]);
                    sum_b = sum_b + SUM_W'(win_reg[i][j][3*CH_W-1:2*CH_W]);
                end
            end
        end
    end

    assign num        = 4'(({2'b00, dy_reg} + 4'd1) * ({2'b00, dx_reg} + 4'd1));
    assign out_r32    = 32'(r_reg) - 32'(dy_reg);
    assign out_c32    = 32'(c_reg) - 32'(dx_reg);
    assign meta.row   = out_r32[POS_W-1:0];
    assign meta.col   = out_c32[POS_W-1:0];
    assign meta.last  = done_y && done_x;
    assign mean_valid = (state_reg == ST_EMIT);

    fbb_mean u_mean (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (mean_valid),
        .in_ready (mean_ready),
        .in_sum_r (sum_r),
        .in_sum_g (sum_g),
        .in_sum_b (sum_b),
        .in_num   (num),
        .in_meta  (meta),
        .res      (res)
    );

    `FBB_ASSERT_NEXT(a_accept_reads, pix.valid && pix.ready, state_reg == ST_RD)
    `FBB_ASSERT_IMPL(a_col_in_frame, state_reg == ST_IDLE, NW'(col_cnt_reg) < n_eff)
    `FBB_ASSERT_IMPL(a_emit_bounded, state_reg == ST_EMIT, dx_reg <= dxhi_reg)

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: box blur regression bench
// Drives pixel frames of several sizes through the 3x3 box blur, predicts
// every windowed mean in a local line-store model and checks each result
// request in order, under random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_top;
    import fbb_pkg::*;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        logic             last;
    } blur_px_t;

    typedef struct {
        bit               is_size;
        logic [CFG_W-1:0] size;
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        bit               typed;
        blur_px_t         want;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    fbb_px_if  pix_ch();
    fbb_res_if res_ch();

    forward_box_blur_3x3_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .pix       (pix_ch),
        .res       (res_ch)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // blur model state
    logic [PIX_W-1:0] older_line [1024];
    logic [PIX_W-1:0] newer_line [1024];
    logic [PIX_W-1:0] prev1, prev2;
    int               at_row, at_col, edge_n;

    blur_px_t   pending_means [$];
    plan_row_t  plan [$];
    int         errors, pixels_sent, means_seen, frames_sent;
    bit         calm;

    function automatic logic [PIX_W-1:0] tap(int back, int k, int c, logic [PIX_W-1:0] cur);
        if (back == 0)
        begin
            if (k == c)
                return cur;
            if (k + 1 == c)
                return prev1;
            return prev2;
        end
        return back == 1 ? newer_line[k] : older_line[k];
    endfunction

    function automatic void set_size(logic [CFG_W-1:0] v);
        edge_n = (v == 0) ? 1 : (v > 1024) ? 1024 : int'(v);
        at_row = 0;
        at_col = 0;
        prev1 = '0;
        prev2 = '0;
    endfunction

    function automatic void predict_means(logic [PIX_W-1:0] cur);
        int n, r, c, y0, y1, x0, x1, ye, xe, sr, sg, sb, num, cnt;
        bit hy, hx;
        logic [PIX_W-1:0] p, t;
        blur_px_t o;
        n = edge_n;
        r = at_row >= n ? 0 : at_row;
        c = at_col >= n ? 0 : at_col;
        cnt = 0;
        if (r == n - 1)
        begin
            y0 = n >= 3 ? n - 3 : 0; y1 = r; hy = 1;
        end
        else
        begin
            hy = r >= 2; y0 = hy ? r - 2 : 0; y1 = y0;
        end
        if (c == n - 1)
        begin
            x0 = n >= 3 ? n - 3 : 0; x1 = c; hx = 1;
        end
        else
        begin
            hx = c >= 2; x0 = hx ? c - 2 : 0; x1 = x0;
        end
        if (hy && hx)
        begin
            for (int y = y0; y <= y1; y++)
            begin
                for (int x = x0; x <= x1; x++)
                begin
                    ye = (y + 2 < n) ? y + 2 : n - 1;
                    xe = (x + 2 < n) ? x + 2 : n - 1;
                    sr = 0; sg = 0; sb = 0; num = 0;
                    for (int yy = y; yy <= ye; yy++)
                    begin
                        for (int xx = x; xx <= xe; xx++)
                        begin
                            p = tap(r - yy, xx, c, cur);
                            sr += p[15:0];
                            sg += p[31:16];
                            sb += p[47:32];
                            num++;
                        end
                    end
                    o.row   = y[POS_W-1:0];
                    o.col   = x[POS_W-1:0];
                    o.red   = 16'(sr / num);
                    o.green = 16'(sg / num);
                    o.blue  = 16'(sb / num);
                    o.last  = (y == y1) && (x == x1);
                    pending_means.push_back(o);
                end
            end
        end
        if (c == n - 1)
        begin
            for (int k = (c >= 2 ? c - 2 : 0); k <= c; k++)
                older_line[k] = tap(0, k, c, cur);
            for (int k = 0; k < n; k++)
            begin
                t = older_line[k];
                older_line[k] = newer_line[k];
                newer_line[k] = t;
            end
            prev1 = '0;
            prev2 = '0;
            at_col = 0;
            at_row = (r + 1 >= n) ? 0 : r + 1;
        end
        else
        begin
            if (c >= 2)
                older_line[c - 2] = prev2;
            prev2 = prev1;
            prev1 = cur;
            at_col = c + 1;
            at_row = r;
        end
    endfunction

    task automatic settle();
        while (pending_means.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_size(logic [CFG_W-1:0] v);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        set_size(v);
    endtask

    task automatic send_pixel(logic [CH_W-1:0] r, logic [CH_W-1:0] g, logic [CH_W-1:0] b);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            pix_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_ch.valid    <= 1'b1;
        pix_ch.red_in   <= r;
        pix_ch.green_in <= g;
        pix_ch.blue_in  <= b;
        do
            @(posedge clk);
        while (!pix_ch.ready);
        predict_means({b, g, r});
        pixels_sent++;
    endtask

    function automatic logic [CH_W-1:0] rand_chan();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return 16'($urandom);
        endcase
    endfunction

    // result side: stall, then hold ready until a request moves
    initial
    begin
        int stall;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!res_ch.valid);
        end
    end

    always @(posedge clk)
    begin
        blur_px_t got, want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got = '{res_ch.out_row, res_ch.out_col, res_ch.red_out, res_ch.green_out,
                    res_ch.blue_out, res_ch.last_of_run};
            means_seen++;
            if (pending_means.size() == 0)
            begin
                $display("%0t unexpected result: got %p", $time, got);
                errors++;
            end
            else
            begin
                want = pending_means.pop_front();
                if (got !== want)
                begin
                    $display("%0t mismatch: expected %p, got %p", $time, want, got);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #30000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        int n, total, extra;
        blur_px_t w;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        pix_ch.valid = 1'b0;
        pix_ch.red_in = '0;
        pix_ch.green_in = '0;
        pix_ch.blue_in = '0;
        errors = 0; pixels_sent = 0; means_seen = 0; frames_sent = 0;
        calm = 1'b0;
        set_size(11'd1024);
        w = '0;

        // full-size frame after reset: first row releases nothing
        plan.push_back('{0, 0, 16'h0000, 16'hFFFF, 16'h8001, 0, w});
        plan.push_back('{0, 0, 16'hFFFF, 16'h0000, 16'h7FFE, 0, w});
        plan.push_back('{0, 0, 16'h5555, 16'hAAAA, 16'h0F0F, 0, w});
        // size zero acts as one: output mirrors input
        plan.push_back('{1, 11'd0, 0, 0, 0, 0, w});
        plan.push_back('{0, 0, 16'hFFFF, 16'h0000, 16'hFFFF, 1,
                         '{10'd0, 10'd0, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b1}});
        plan.push_back('{0, 0, 16'h0000, 16'hFFFF, 16'h0000, 1,
                         '{10'd0, 10'd0, 16'h0000, 16'hFFFF, 16'h0000, 1'b1}});
        // oversize clamps to the maximum
        plan.push_back('{1, 11'd2047, 0, 0, 0, 0, w});
        plan.push_back('{0, 0, 16'h1234, 16'h5678, 16'h9ABC, 0, w});
        plan.push_back('{0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, w});
        plan.push_back('{1, 11'd1, 0, 0, 0, 0, w});
        plan.push_back('{0, 0, 16'h1234, 16'h5678, 16'h9ABC, 1,
                         '{10'd0, 10'd0, 16'h1234, 16'h5678, 16'h9ABC, 1'b1}});
        plan.push_back('{1, 11'd2, 0, 0, 0, 0, w});
        plan.push_back('{0, 0, 16'hFFFF, 16'h0000, 16'h0001, 0, w});
        plan.push_back('{0, 0, 16'hFFFE, 16'h0003, 16'hFFFF, 0, w});
        plan.push_back('{0, 0, 16'h0000, 16'hFFFF, 16'h8000, 0, w});
        plan.push_back('{0, 0, 16'h0007, 16'hFFFF, 16'h7FFF, 0, w});
        plan.push_back('{1, 11'd3, 0, 0, 0, 0, w});
        for (int i = 0; i < 9; i++)
            plan.push_back('{0, 0, (i % 2) ? 16'hFFFF : 16'h0000, 16'hFFFF - 16'(i),
                             16'(i * 7000), 0, w});

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_size)
            begin
                pix_ch.valid <= 1'b0;
                write_size(plan[i].size);
            end
            else
            begin
                send_pixel(plan[i].red, plan[i].green, plan[i].blue);
                if (plan[i].typed)
                begin
                    void'(pending_means.pop_back());
                    pending_means.push_back(plan[i].want);
                end
            end
        end

        // maximum size, a stretch of the first row
        pix_ch.valid <= 1'b0;
        write_size(11'd1024);
        for (int i = 0; i < 40; i++)
            send_pixel(rand_chan(), rand_chan(), rand_chan());

        total = 0;
        while (total < 240)
        begin
            calm = ($urandom_range(0, 4) == 0);
            n = ($urandom_range(0, 4) == 0) ? 3 : $urandom_range(1, 10);
            pix_ch.valid <= 1'b0;
            write_size(11'(n));
            extra = ($urandom_range(0, 2) == 0) ? 2 : 1;
            for (int f = 0; f < extra; f++)
            begin
                // drop part of the frame now and then
                int cnt;
                cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(1, n * n) : n * n;
                for (int i = 0; i < cnt; i++)
                    send_pixel(rand_chan(), rand_chan(), rand_chan());
                total += cnt;
                frames_sent++;
            end
        end

        pix_ch.valid <= 1'b0;
        calm = 1'b0;
        settle();
        repeat (20) @(posedge clk);
        $display("Covered %0d source pixels in %0d random frames of sizes 1 to 10 plus max size,",
                 pixels_sent, frames_sent);
        $display("with %0d blurred results checked and %0d mismatches.", means_seen, errors);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ forward_box_blur_3x3_unit.f @@
+incdir+rtl
rtl/fbb_pkg.sv
rtl/fbb_px_if.sv
rtl/fbb_res_if.sv
rtl/fbb_line_mem.sv
rtl/fbb_mean.sv
rtl/forward_box_blur_3x3_unit.sv
bench/tb_top.sv
